### sv/tccs_pkg.sv
// shared types and constants for the text console block
`default_nettype none
package tccs_pkg;

	localparam int KIND_W = 2;
	localparam int BYTE_W = 8;
	localparam int ROW_W  = 5;
	localparam int COL_W  = 7;
	localparam int CELL_W = 16;
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;

	localparam logic [KIND_W-1:0] KIND_PUT  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_SET  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_READ = 2'd2;

	localparam logic [BYTE_W-1:0] CH_SPACE     = 8'd32;
	localparam logic [BYTE_W-1:0] CH_NEWLINE   = 8'd10;
	localparam logic [BYTE_W-1:0] CH_BACKSPACE = 8'd8;
	localparam logic [BYTE_W-1:0] CH_RETURN    = 8'd13;

	localparam logic [BYTE_W-1:0] COLOR_AT_RESET = 8'd2;

	localparam logic [APB_ADDR_W-3:0] REG_TEXT_COLOR = 1'd0;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_SCROLL,
		ST_BLANK,
		ST_RESULT
	} state_t;

endpackage
`default_nettype wire

### sv/tccs_mem.sv
// screen cell store, one write port and one registered read port
`default_nettype none
module tccs_mem #(
	parameter int DEPTH  = 2000,
	parameter int ADDR_W = 11
) (
	input  wire                          clk,
	input  wire                          we,
	input  wire [ADDR_W-1:0]             waddr,
	input  wire [tccs_pkg::CELL_W-1:0]   wdata,
	input  wire                          re,
	input  wire [ADDR_W-1:0]             raddr,
	output logic [tccs_pkg::CELL_W-1:0]  rdata
);

	logic [tccs_pkg::CELL_W-1:0] mem_q [DEPTH];
	logic [tccs_pkg::CELL_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

### sv/tccs_ctrl.sv
// sequencer: cursor, put byte, scroll and clear sweeps, result register
`default_nettype none
module tccs_ctrl #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25,
	parameter int CELLS   = 2000,
	parameter int ADDR_W  = 11
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire [tccs_pkg::BYTE_W-1:0]        text_color,
	input  wire                               in_valid,
	output logic                              in_ready,
	input  wire [tccs_pkg::KIND_W-1:0]        kind,
	input  wire [tccs_pkg::BYTE_W-1:0]        byte_in,
	input  wire [tccs_pkg::ROW_W-1:0]         row_in,
	input  wire [tccs_pkg::COL_W-1:0]         col_in,
	output logic                              out_valid,
	input  wire                               out_ready,
	output logic [tccs_pkg::BYTE_W-1:0]       cell_char,
	output logic [tccs_pkg::BYTE_W-1:0]       cell_color,
	output logic [tccs_pkg::ROW_W-1:0]        caret_row,
	output logic [tccs_pkg::COL_W-1:0]        caret_col,
	output logic                              mem_we,
	output logic [ADDR_W-1:0]                 mem_waddr,
	output logic [tccs_pkg::CELL_W-1:0]       mem_wdata,
	output logic                              mem_re,
	output logic [ADDR_W-1:0]                 mem_raddr,
	input  wire [tccs_pkg::CELL_W-1:0]        mem_rdata
);

	localparam logic [tccs_pkg::ROW_W-1:0] LAST_ROW = tccs_pkg::ROW_W'(ROWS - 1);
	localparam logic [tccs_pkg::COL_W-1:0] LAST_COL = tccs_pkg::COL_W'(COLUMNS - 1);
	localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
	localparam logic [ADDR_W-1:0] LAST_COPY = ADDR_W'(CELLS - COLUMNS - 1);

	tccs_pkg::state_t state_q, state_d;

	logic [tccs_pkg::KIND_W-1:0] kind_q;
	logic [tccs_pkg::BYTE_W-1:0] byte_q;
	logic [tccs_pkg::ROW_W-1:0]  row_q;
	logic [tccs_pkg::COL_W-1:0]  col_q;

	logic [tccs_pkg::ROW_W-1:0]  cur_row_q, cur_row_d;
	logic [tccs_pkg::COL_W-1:0]  cur_col_q, cur_col_d;
	logic [ADDR_W-1:0]           k_q, k_d;

	logic                        wr_valid_s1, wr_valid_d;
	logic                        wr_copy_s1, wr_copy_d;
	logic [ADDR_W-1:0]           wr_addr_s1, wr_addr_d;
	logic [tccs_pkg::CELL_W-1:0] wr_data_s1, wr_data_d;

	logic                        out_valid_q;
	logic [tccs_pkg::BYTE_W-1:0] cell_char_q, cell_color_q;
	logic [tccs_pkg::ROW_W-1:0]  caret_row_q;
	logic [tccs_pkg::COL_W-1:0]  caret_col_q;

	logic                        accept;
	logic                        load_out;
	logic                        last_row, last_col;
	logic                        scroll_go;
	logic [ADDR_W-1:0]           pos;

	assign accept   = in_valid && in_ready;
	assign last_row = (cur_row_q == LAST_ROW);
	assign last_col = (cur_col_q == LAST_COL);
	assign pos      = ADDR_W'(cur_row_q * COLUMNS + cur_col_q);

	always_comb begin
		scroll_go = 1'b0;
		if (kind_q == tccs_pkg::KIND_PUT) begin
			case (byte_q)
				tccs_pkg::CH_NEWLINE:   scroll_go = last_row;
				tccs_pkg::CH_BACKSPACE: scroll_go = 1'b0;
				tccs_pkg::CH_RETURN:    scroll_go = 1'b0;
				default:                scroll_go = last_row && last_col;
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tccs_pkg::ST_CLEAR: begin
				if (k_q == LAST_CELL) state_d = tccs_pkg::ST_IDLE;
			end
			tccs_pkg::ST_IDLE: begin
				if (in_valid) state_d = tccs_pkg::ST_EXEC;
			end
			tccs_pkg::ST_EXEC: begin
				if (scroll_go) state_d = tccs_pkg::ST_SCROLL;
				else state_d = tccs_pkg::ST_RESULT;
			end
			tccs_pkg::ST_SCROLL: begin
				if (k_q == LAST_COPY) state_d = tccs_pkg::ST_BLANK;
			end
			tccs_pkg::ST_BLANK: begin
				if (k_q == LAST_CELL) state_d = tccs_pkg::ST_RESULT;
			end
			tccs_pkg::ST_RESULT: begin
				if (!out_valid_q || out_ready) state_d = tccs_pkg::ST_IDLE;
			end
			default: state_d = tccs_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_ready   = 1'b0;
		mem_re     = 1'b0;
		mem_raddr  = '0;
		wr_valid_d = 1'b0;
		wr_copy_d  = 1'b0;
		wr_addr_d  = wr_addr_s1;
		wr_data_d  = wr_data_s1;
		cur_row_d  = cur_row_q;
		cur_col_d  = cur_col_q;
		k_d        = k_q;
		load_out   = 1'b0;
		unique case (state_q)
			tccs_pkg::ST_CLEAR: begin
				wr_valid_d = 1'b1;
				wr_addr_d  = k_q;
				wr_data_d  = {tccs_pkg::COLOR_AT_RESET, tccs_pkg::CH_SPACE};
				k_d        = k_q + 1'b1;
			end
			tccs_pkg::ST_IDLE: begin
				in_ready = 1'b1;
			end
			tccs_pkg::ST_EXEC: begin
				k_d = '0;
				case (kind_q)
					tccs_pkg::KIND_PUT: begin
						case (byte_q)
							tccs_pkg::CH_NEWLINE: begin
								cur_col_d = '0;
								if (!last_row) cur_row_d = cur_row_q + 1'b1;
							end
							tccs_pkg::CH_BACKSPACE: begin
								if (cur_col_q != '0) begin
									cur_col_d = cur_col_q - 1'b1;
								end else if (cur_row_q != '0) begin
									cur_row_d = cur_row_q - 1'b1;
									cur_col_d = LAST_COL;
								end
								if (pos > ADDR_W'(1)) begin
									wr_valid_d = 1'b1;
									wr_addr_d  = pos - 1'b1;
									wr_data_d  = {text_color, tccs_pkg::CH_SPACE};
								end
							end
							tccs_pkg::CH_RETURN: begin
								cur_col_d = '0;
							end
							default: begin
								wr_valid_d = 1'b1;
								wr_addr_d  = pos;
								wr_data_d  = {text_color, byte_q};
								if (last_col) begin
									cur_col_d = '0;
									if (!last_row) cur_row_d = cur_row_q + 1'b1;
								end else begin
									cur_col_d = cur_col_q + 1'b1;
								end
							end
						endcase
					end
					tccs_pkg::KIND_SET: begin
						cur_row_d = row_q;
						cur_col_d = col_q;
					end
					tccs_pkg::KIND_READ: begin
						mem_re    = 1'b1;
						mem_raddr = ADDR_W'(row_q * COLUMNS + col_q);
					end
					default: ;
				endcase
			end
			tccs_pkg::ST_SCROLL: begin
				mem_re     = 1'b1;
				mem_raddr  = ADDR_W'(k_q + COLUMNS);
				wr_valid_d = 1'b1;
				wr_copy_d  = 1'b1;
				wr_addr_d  = k_q;
				wr_data_d  = {text_color, tccs_pkg::CH_SPACE};
				k_d        = k_q + 1'b1;
			end
			tccs_pkg::ST_BLANK: begin
				wr_valid_d = 1'b1;
				wr_addr_d  = k_q;
				wr_data_d  = {text_color, tccs_pkg::CH_SPACE};
				k_d        = k_q + 1'b1;
			end
			tccs_pkg::ST_RESULT: begin
				load_out = !out_valid_q || out_ready;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tccs_pkg::ST_CLEAR;
			cur_row_q   <= '0;
			cur_col_q   <= '0;
			k_q         <= '0;
			wr_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cur_row_q   <= cur_row_d;
			cur_col_q   <= cur_col_d;
			k_q         <= k_d;
			wr_valid_s1 <= wr_valid_d;
			if (load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		wr_copy_s1 <= wr_copy_d;
		wr_addr_s1 <= wr_addr_d;
		wr_data_s1 <= wr_data_d;
		if (accept) begin
			kind_q <= kind;
			byte_q <= byte_in;
			row_q  <= (row_in > LAST_ROW) ? LAST_ROW : row_in;
			col_q  <= (col_in > LAST_COL) ? LAST_COL : col_in;
		end
		if (load_out) begin
			caret_row_q <= cur_row_q;
			caret_col_q <= cur_col_q;
			if (kind_q == tccs_pkg::KIND_READ) begin
				cell_char_q  <= mem_rdata[7:0];
				cell_color_q <= mem_rdata[15:8];
			end else begin
				cell_char_q  <= '0;
				cell_color_q <= '0;
			end
		end
	end

	// copy writes take the character just read one row below
	assign mem_we    = wr_valid_s1;
	assign mem_waddr = wr_addr_s1;
	assign mem_wdata = wr_copy_s1 ? {wr_data_s1[15:8], mem_rdata[7:0]} : wr_data_s1;

	assign out_valid  = out_valid_q;
	assign cell_char  = cell_char_q;
	assign cell_color = cell_color_q;
	assign caret_row  = caret_row_q;
	assign caret_col  = caret_col_q;

endmodule
`default_nettype wire

### sv/text_console_cursor_scroll.sv
// top level of the text console: color register, sequencer and cell store
// Text console with a ROWS x COLUMNS store of character/color cells and a
// cursor. After reset the block sweeps the store to spaces in the reset color,
// one cell a cycle, before it takes its first item; the text_color register
// can be written during that sweep. A put byte, set cursor or read cell item
// passes from acceptance through one store access in the EXEC state, then the
// RESULT state loads the result register, and the next item is taken only
// after the block has returned to idle. A put byte that scrolls walks the
// store one cell per cycle through its single write port before its result
// is loaded. A new item is accepted while the previous result still waits in
// the output register. Write text_color only while idle.
`default_nettype none
module text_console_cursor_scroll #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 psel,
	input  wire                                 penable,
	input  wire                                 pwrite,
	input  wire [tccs_pkg::APB_ADDR_W-1:0]      paddr,
	input  wire [tccs_pkg::APB_DATA_W-1:0]      pwdata,
	output logic [tccs_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                pready,
	input  wire                                 in_valid,
	output logic                                in_ready,
	input  wire [tccs_pkg::KIND_W-1:0]          kind,
	input  wire [tccs_pkg::BYTE_W-1:0]          byte_in,
	input  wire [tccs_pkg::ROW_W-1:0]           row_in,
	input  wire [tccs_pkg::COL_W-1:0]           col_in,
	output logic                                out_valid,
	input  wire                                 out_ready,
	output logic [tccs_pkg::BYTE_W-1:0]         cell_char,
	output logic [tccs_pkg::BYTE_W-1:0]         cell_color,
	output logic [tccs_pkg::ROW_W-1:0]          caret_row,
	output logic [tccs_pkg::COL_W-1:0]          caret_col
);

	localparam int CELLS  = ROWS * COLUMNS;
	localparam int ADDR_W = $clog2(CELLS);

	logic [tccs_pkg::BYTE_W-1:0] text_color_q;
	logic                        cfg_wr;

	logic                        mem_we;
	logic [ADDR_W-1:0]           mem_waddr;
	logic [tccs_pkg::CELL_W-1:0] mem_wdata;
	logic                        mem_re;
	logic [ADDR_W-1:0]           mem_raddr;
	logic [tccs_pkg::CELL_W-1:0] mem_rdata;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite
		&& (paddr[tccs_pkg::APB_ADDR_W-1:2] == tccs_pkg::REG_TEXT_COLOR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_color_q <= tccs_pkg::COLOR_AT_RESET;
		end else if (cfg_wr) begin
			text_color_q <= pwdata[tccs_pkg::BYTE_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[tccs_pkg::APB_ADDR_W-1:2] == tccs_pkg::REG_TEXT_COLOR) begin
			prdata = {{(tccs_pkg::APB_DATA_W-tccs_pkg::BYTE_W){1'b0}}, text_color_q};
		end
	end

	tccs_ctrl #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS),
		.CELLS   (CELLS),
		.ADDR_W  (ADDR_W)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_color (text_color_q),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.kind       (kind),
		.byte_in    (byte_in),
		.row_in     (row_in),
		.col_in     (col_in),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.cell_char  (cell_char),
		.cell_color (cell_color),
		.caret_row  (caret_row),
		.caret_col  (caret_col),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_re     (mem_re),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata)
	);

	tccs_mem #(
		.DEPTH  (CELLS),
		.ADDR_W (ADDR_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule
`default_nettype wire
